>>> sv/mmsu_pkg.sv
`default_nettype none
package mmsu_pkg;

  localparam int MAX_SAMPLES = 16;
  localparam int MAX_DESIGNS = 8;
  localparam int ROW_W       = $clog2(MAX_SAMPLES);
  localparam int DES_W       = $clog2(MAX_DESIGNS);
  localparam int ND_W        = $clog2(MAX_DESIGNS + 1);
  localparam int ADDR_W      = ROW_W + DES_W;
  // wide datapath of the solver: holds (d * v) << 16 and (p^2 * n) << 32
  localparam int WW          = 192;

  typedef enum logic [1:0] {
    CMD_DESIGN = 2'd0,
    CMD_NORM   = 2'd1,
    CMD_SAMPLE = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_PRIOR_MODE = 1'b0,
    REG_DESIGNS    = 1'b1
  } reg_idx_t;

  // one solve request from front to back
  typedef struct packed {
    logic [DES_W-1:0]   idx;
    logic signed [63:0] proj;
    logic [31:0]        norm;
    logic [31:0]        noise;
    logic               k3;
    logic               last;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_RD,
    F_MUL,
    F_ADD,
    F_EMIT
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_NV,
    B_CHK,
    B_MUL,
    B_DCHK,
    B_DIV,
    B_DDONE,
    B_OUT
  } back_state_t;

  typedef enum logic [2:0] {
    PH_P2,
    PH_DEN1,
    PH_PHI,
    PH_DEN2,
    PH_EST,
    PH_NUM3,
    PH_DEN3,
    PH_VAR
  } phase_t;

endpackage
`default_nettype wire

>>> sv/mmsu_fifo.sv
`default_nettype none
module mmsu_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire mmsu_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output mmsu_pkg::job_t     pop_job
);
  import mmsu_pkg::*;

  job_t       slots_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_job   = slots_r[rd_ptr_r];

  // store request
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr_r <= !wr_ptr_r;
      if (pop && not_empty) rd_ptr_r <= !rd_ptr_r;
      case ({push && !full, pop && not_empty})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/mmsu_front.sv
`default_nettype none
module mmsu_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_command,
  input  wire logic [3:0]          in_row_index,
  input  wire logic [2:0]          in_design_column,
  input  wire logic signed [31:0]  in_sample_value,
  input  wire logic [31:0]         in_noise_variance,
  input  wire logic                in_last_in_column,
  input  wire logic                prior_mode,
  input  wire logic [3:0]          designs_in_use,
  output logic                     job_push,
  output mmsu_pkg::job_t           job,
  input  wire logic                job_full
);
  import mmsu_pkg::*;

  logic [31:0]        mem [MAX_SAMPLES*MAX_DESIGNS];
  logic [31:0]        rd_data_r;
  logic [31:0]        norms_r [MAX_DESIGNS];
  logic signed [63:0] sums_r [MAX_DESIGNS];

  front_state_t       state_r, state_nxt;
  logic [ND_W-1:0]    m_r;
  logic [ROW_W-1:0]   cnt_r;
  logic signed [31:0] val_r;
  logic [31:0]        noise_r;
  logic               last_r;
  logic signed [63:0] prod_r;

  logic [ND_W-1:0]    nd;
  logic               accept;
  logic               is_sample;
  logic [DES_W-1:0]   m_idx;
  logic               acc_done;
  logic signed [64:0] sum_ext;
  logic signed [63:0] sum_sat;
  logic [ROW_W-1:0]   cnt_inc;

  assign nd = (designs_in_use > ND_W'(MAX_DESIGNS)) ? ND_W'(MAX_DESIGNS) : designs_in_use;
  assign in_stall  = (state_r != F_IDLE);
  assign accept    = in_valid && !in_stall;
  assign is_sample = (cmd_t'(in_command) == CMD_SAMPLE);
  assign m_idx     = m_r[DES_W-1:0];
  assign acc_done  = (m_r + ND_W'(1)) == nd;
  assign cnt_inc   = (cnt_r == ROW_W'(MAX_SAMPLES - 1)) ? '0 : cnt_r + ROW_W'(1);

  // saturating add of the product into the selected sum
  assign sum_ext = {sums_r[m_idx][63], sums_r[m_idx]} + {prod_r[63], prod_r};
  always_comb begin
    if (sum_ext[64] != sum_ext[63]) begin
      sum_sat = sum_ext[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sum_sat = sum_ext[63:0];
    end
  end

  // request to the solver queue
  assign job_push   = (state_r == F_EMIT) && (m_r < nd) && !job_full;
  assign job.idx    = m_idx;
  assign job.proj   = sums_r[m_idx];
  assign job.norm   = norms_r[m_idx];
  assign job.noise  = noise_r;
  assign job.k3     = prior_mode;
  assign job.last   = acc_done;

  // design store: write on load, registered read
  always_ff @(posedge clk) begin
    if (accept && cmd_t'(in_command) == CMD_DESIGN) begin
      mem[{in_design_column, in_row_index}] <= in_sample_value;
    end
    rd_data_r <= mem[{m_idx, cnt_r}];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept && is_sample) begin
          if (nd != '0) state_nxt = F_RD;
          else if (in_last_in_column) state_nxt = F_EMIT;
        end
      end
      F_RD:  state_nxt = F_MUL;
      F_MUL: state_nxt = F_ADD;
      F_ADD: begin
        if (!acc_done) state_nxt = F_RD;
        else if (last_r) state_nxt = F_EMIT;
        else state_nxt = F_IDLE;
      end
      F_EMIT: begin
        if (m_r >= nd) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= F_IDLE;
    else state_r <= state_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r   <= '0;
      cnt_r <= '0;
      for (int i = 0; i < MAX_DESIGNS; i++) sums_r[i] <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          m_r <= '0;
          if (accept && cmd_t'(in_command) == CMD_NORM) begin
            norms_r[in_design_column] <= in_sample_value;
          end
          if (accept && is_sample) begin
            val_r   <= in_sample_value;
            noise_r <= in_noise_variance;
            last_r  <= in_last_in_column;
            if (nd == '0 && !in_last_in_column) cnt_r <= cnt_inc;
          end
        end
        F_RD: ;
        F_MUL: prod_r <= 64'($signed(rd_data_r)) * 64'(val_r);
        F_ADD: begin
          sums_r[m_idx] <= sum_sat;
          if (acc_done) begin
            m_r <= '0;
            if (!last_r) cnt_r <= cnt_inc;
          end else begin
            m_r <= m_r + ND_W'(1);
          end
        end
        F_EMIT: begin
          if (m_r >= nd) begin
            // column end: clear every sum and the row counter
            for (int i = 0; i < MAX_DESIGNS; i++) sums_r[i] <= '0;
            cnt_r <= '0;
            m_r   <= '0;
          end else if (!job_full) begin
            m_r <= m_r + ND_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/mmsu_solver.sv
`default_nettype none
module mmsu_solver (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           job_valid,
  input  wire mmsu_pkg::job_t job,
  output logic                job_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [2:0]          out_design_index,
  output logic signed [31:0]  out_estimate,
  output logic [31:0]         out_estimate_variance,
  output logic [31:0]         out_shrink_factor,
  output logic                out_last_of_run
);
  import mmsu_pkg::*;

  back_state_t      state_r, state_nxt;
  phase_t           phase_r;

  logic [WW-1:0]    ma_r, acc_r, p2_r, d_r, nvk_r, num_r, den_r, dsh_r;
  logic [63:0]      mb_r;
  logic [63:0]      mag_r;
  logic             neg_r, npos_r, k3_r, last_r;
  logic [31:0]      n_r, v_r;
  logic [DES_W-1:0] idx_r;
  logic [4:0]       bit_r;
  logic [31:0]      q_r, phi_r, e_r, var_r;
  logic             out_valid_r;

  logic [63:0]      nv, nn;
  logic [65:0]      nvk;
  logic [33:0]      vk;
  logic             div_sat, ge, out_load;
  logic [31:0]      est;

  assign nv  = 64'(n_r) * 64'(v_r);
  assign nn  = 64'(n_r) * 64'(n_r);
  assign nvk = k3_r ? (66'(nv) + {1'b0, nv, 1'b0}) : 66'(nv);
  assign vk  = k3_r ? (34'(v_r) + {1'b0, v_r, 1'b0}) : 34'(v_r);
  assign div_sat = (den_r == '0) || (num_r >= {den_r[WW-33:0], 32'd0});
  assign ge = (num_r >= dsh_r);
  assign out_load = (state_r == B_OUT) && (!out_valid_r || !out_stall);
  assign job_pop  = (state_r == B_IDLE) && job_valid;
  assign out_valid = out_valid_r;

  // saturate the signed estimate
  always_comb begin
    if (neg_r) begin
      est = 32'd0 - ((e_r > 32'h8000_0000) ? 32'h8000_0000 : e_r);
    end else begin
      est = (e_r > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : e_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (job_valid) state_nxt = B_NV;
      B_NV:   state_nxt = B_MUL;
      B_CHK: begin
        if (!npos_r || p2_r <= nvk_r) state_nxt = B_OUT;
        else state_nxt = B_MUL;
      end
      B_MUL: begin
        if (mb_r == '0) begin
          unique case (phase_r)
            PH_P2:   state_nxt = B_CHK;
            PH_NUM3: state_nxt = B_MUL;
            default: state_nxt = B_DCHK;
          endcase
        end
      end
      B_DCHK: state_nxt = div_sat ? B_DDONE : B_DIV;
      B_DIV:  if (bit_r == '0) state_nxt = B_DDONE;
      B_DDONE: state_nxt = (phase_r == PH_VAR) ? B_OUT : B_MUL;
      B_OUT:  if (out_load) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= B_IDLE;
    else state_r <= state_nxt;
  end

  // datapath: shared shift-add multiplier and restoring divider
  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          mag_r  <= job.proj[63] ? (64'd0 - job.proj) : job.proj;
          neg_r  <= job.proj[63];
          n_r    <= job.norm;
          npos_r <= !job.norm[31] && (job.norm != '0);
          v_r    <= job.noise;
          k3_r   <= job.k3;
          idx_r  <= job.idx;
          last_r <= job.last;
        end
      end
      B_NV: begin
        nvk_r   <= WW'({nvk, 32'd0});
        ma_r    <= WW'(mag_r);
        mb_r    <= mag_r;
        acc_r   <= '0;
        phase_r <= PH_P2;
      end
      B_CHK: begin
        if (!npos_r || p2_r <= nvk_r) begin
          phi_r <= '0;
          e_r   <= '0;
          var_r <= '0;
        end else begin
          d_r     <= p2_r - nvk_r;
          ma_r    <= WW'(nn);
          mb_r    <= 64'(vk);
          acc_r   <= '0;
          phase_r <= PH_DEN1;
        end
      end
      B_MUL: begin
        if (mb_r != '0) begin
          if (mb_r[0]) acc_r <= acc_r + ma_r;
          ma_r <= {ma_r[WW-2:0], 1'b0};
          mb_r <= {1'b0, mb_r[63:1]};
        end else begin
          unique case (phase_r)
            PH_P2: p2_r <= acc_r;
            PH_DEN1: begin
              den_r <= acc_r; num_r <= d_r; phase_r <= PH_PHI;
            end
            PH_DEN2: begin
              den_r <= acc_r; num_r <= d_r; phase_r <= PH_EST;
            end
            PH_NUM3: begin
              num_r   <= {acc_r[WW-17:0], 16'd0};
              ma_r    <= p2_r;
              mb_r    <= 64'(n_r);
              acc_r   <= '0;
              phase_r <= PH_DEN3;
            end
            PH_DEN3: begin
              den_r <= acc_r; phase_r <= PH_VAR;
            end
            default: ;
          endcase
        end
      end
      B_DCHK: begin
        if (div_sat) begin
          q_r <= '1;
        end else begin
          dsh_r <= {den_r[WW-32:0], 31'd0};
          bit_r <= 5'd31;
          q_r   <= '0;
        end
      end
      B_DIV: begin
        if (ge) begin
          num_r        <= num_r - dsh_r;
          q_r[bit_r]   <= 1'b1;
        end
        dsh_r <= {1'b0, dsh_r[WW-1:1]};
        if (bit_r != '0) bit_r <= bit_r - 5'd1;
      end
      B_DDONE: begin
        unique case (phase_r)
          PH_PHI: begin
            phi_r   <= q_r;
            ma_r    <= WW'(mag_r);
            mb_r    <= 64'(n_r);
            acc_r   <= '0;
            phase_r <= PH_DEN2;
          end
          PH_EST: begin
            e_r     <= q_r;
            ma_r    <= d_r;
            mb_r    <= 64'(v_r);
            acc_r   <= '0;
            phase_r <= PH_NUM3;
          end
          default: var_r <= q_r;
        endcase
      end
      B_OUT: ;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_design_index      <= idx_r;
      out_estimate          <= est;
      out_estimate_variance <= var_r;
      out_shrink_factor     <= phi_r;
      out_last_of_run       <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

endmodule
`default_nettype wire

>>> sv/map_marginal_shrinkage_unit.sv
`default_nettype none
// Channel  Handshake            Carries
// in_      in_valid / in_stall  command, row, design column, sample, noise, last
// out_     out_valid/out_stall  design index, estimate, variance, phi, last
// cfg_     cfg_valid/cfg_ready  register index, write data (always ready)
//
// A data sample runs through the front once per design in use (memory read,
// 32x32 multiply, saturating add). On the last sample each design in use becomes
// a solve request; the back solves one request with its shift-add multiplier
// (one operand bit a cycle) and its restoring divider (one quotient bit a cycle),
// and skips the divisions when phi is not positive. A 2-entry queue sits between
// front and back.
// Synchronous reset clears control state and all sums.
module map_marginal_shrinkage_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_command,
  input  wire logic [3:0]         in_row_index,
  input  wire logic [2:0]         in_design_column,
  input  wire logic signed [31:0] in_sample_value,
  input  wire logic [31:0]        in_noise_variance,
  input  wire logic               in_last_in_column,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_design_index,
  output logic signed [31:0]      out_estimate,
  output logic [31:0]             out_estimate_variance,
  output logic [31:0]             out_shrink_factor,
  output logic                    out_last_of_run,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [3:0]         cfg_data
);
  import mmsu_pkg::*;

  logic       prior_mode_r;
  logic [3:0] designs_r;
  logic       push, full, pop, not_empty;
  job_t       push_job, pop_job;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_mode_r <= 1'b0;
      designs_r    <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PRIOR_MODE: prior_mode_r <= cfg_data[0];
        REG_DESIGNS:    designs_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  mmsu_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_row_index      (in_row_index),
    .in_design_column  (in_design_column),
    .in_sample_value   (in_sample_value),
    .in_noise_variance (in_noise_variance),
    .in_last_in_column (in_last_in_column),
    .prior_mode        (prior_mode_r),
    .designs_in_use    (designs_r),
    .job_push          (push),
    .job               (push_job),
    .job_full          (full)
  );

  mmsu_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_job   (pop_job)
  );

  mmsu_solver u_solver (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .job_valid             (not_empty),
    .job                   (pop_job),
    .job_pop               (pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_design_index      (out_design_index),
    .out_estimate          (out_estimate),
    .out_estimate_variance (out_estimate_variance),
    .out_shrink_factor     (out_shrink_factor),
    .out_last_of_run       (out_last_of_run)
  );

endmodule
`default_nettype wire
